// ----- rtl/jsu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, status codes, decoder state encoding and helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHAR_W  = 24;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned HEX_W   = 16;

	// Status codes of a result word.
	localparam logic [STAT_W-1:0] STATUS_CHAR    = 3'd0;
	localparam logic [STAT_W-1:0] STATUS_END     = 3'd1;
	localparam logic [STAT_W-1:0] STATUS_NOSTR   = 3'd2;
	localparam logic [STAT_W-1:0] STATUS_BADESC  = 3'd3;
	localparam logic [STAT_W-1:0] STATUS_BADHEX  = 3'd4;

	// Character codes the decoder looks for.
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_B = 8'h62;
	localparam logic [BYTE_W-1:0] CH_F = 8'h66;
	localparam logic [BYTE_W-1:0] CH_N = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_R = 8'h72;
	localparam logic [BYTE_W-1:0] CH_T = 8'h74;
	localparam logic [BYTE_W-1:0] CH_U = 8'h75;
	localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
	localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

	// Decoder phase, one-hot.
	typedef enum logic [6:0] {
		PH_IDLE = 7'b000_0001,
		PH_BODY = 7'b000_0010,
		PH_ESC  = 7'b000_0100,
		PH_HEX1 = 7'b000_1000,
		PH_HEX2 = 7'b001_0000,
		PH_HEX3 = 7'b010_0000,
		PH_HEX4 = 7'b100_0000
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
	} in_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_value;
		logic [STAT_W-1:0] status;
	} out_word_t;

	// Decoder state and its update, passed between the top level and the decoder.
	typedef struct packed {
		phase_t           phase;
		logic [HEX_W-1:0] hex;
	} dec_state_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} dec_result_t;

	// Hex digit value; bit 4 set means the byte is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = {1'b0, 4'(b - 8'h37)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = {1'b0, 4'(b - 8'h57)};
		end
		return v;
	endfunction

	// Code point to packed UTF-8, lead byte highest; codes below 256 stay raw.
	function automatic logic [CHAR_W-1:0] encode_code(input logic [HEX_W-1:0] n);
		logic [CHAR_W-1:0] r;
		if (n < 16'h0100) begin
			r = {16'h0000, n[7:0]};
		end else if (n < 16'h0800) begin
			r = {8'h00, 3'b110, n[10:6], 2'b10, n[5:0]};
		end else begin
			r = {4'b1110, n[15:12], 2'b10, n[11:6], 2'b10, n[5:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/jsu_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape stream interfaces
// Valid/ready channels for text bytes in and decoded characters out.
// ----------------------------------------------------------------------------
interface jsu_in_if
	import jsu_pkg::*;
	;
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jsu_out_if
	import jsu_pkg::*;
	;
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/jsu_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Next-state and result logic for one text byte, given the current state.
// ----------------------------------------------------------------------------
module jsu_decode
	import jsu_pkg::*;
(
	input  dec_state_t        cur,
	input  logic [BYTE_W-1:0] text_byte,
	output dec_state_t        nxt,
	output dec_result_t       res
);

	logic [4:0]       hv;
	logic [HEX_W-1:0] hex_shift;

	assign hv        = hex_value(text_byte);
	assign hex_shift = {cur.hex[HEX_W-5:0], hv[3:0]};

	always_comb begin
		nxt                  = cur;
		res.valid            = 1'b0;
		res.word.char_value  = '0;
		res.word.status      = STATUS_CHAR;
		unique case (cur.phase)
			PH_BODY: begin
				if (text_byte == CH_QUOTE) begin
					nxt.phase       = PH_IDLE;
					res.valid       = 1'b1;
					res.word.status = STATUS_END;
				end else if (text_byte == CH_BSLASH) begin
					nxt.phase = PH_ESC;
				end else begin
					res.valid           = 1'b1;
					res.word.char_value = {16'h0000, text_byte};
				end
			end
			PH_ESC: begin
				nxt.phase = PH_BODY;
				res.valid = 1'b1;
				unique case (text_byte)
					CH_QUOTE, CH_BSLASH, CH_SLASH:
						res.word.char_value = {16'h0000, text_byte};
					CH_B: res.word.char_value = {16'h0000, CH_BS};
					CH_F: res.word.char_value = {16'h0000, CH_FF};
					CH_N: res.word.char_value = {16'h0000, CH_LF};
					CH_R: res.word.char_value = {16'h0000, CH_CR};
					CH_T: res.word.char_value = {16'h0000, CH_TAB};
					CH_U: begin
						res.valid = 1'b0;
						nxt.hex   = '0;
						nxt.phase = PH_HEX1;
					end
					default: begin
						nxt.phase       = PH_IDLE;
						res.word.status = STATUS_BADESC;
					end
				endcase
			end
			PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
				if (hv[4]) begin
					nxt.phase       = PH_IDLE;
					nxt.hex         = '0;
					res.valid       = 1'b1;
					res.word.status = STATUS_BADHEX;
				end else begin
					nxt.hex = hex_shift;
					unique case (cur.phase)
						PH_HEX1: nxt.phase = PH_HEX2;
						PH_HEX2: nxt.phase = PH_HEX3;
						PH_HEX3: nxt.phase = PH_HEX4;
						default: begin
							nxt.phase           = PH_BODY;
							res.valid           = 1'b1;
							res.word.char_value = encode_code(hex_shift);
						end
					endcase
				end
			end
			default: begin
				// Idle, and any unused code, waits for the opening quote.
				if (text_byte == CH_QUOTE) begin
					nxt.phase = PH_BODY;
				end else begin
					nxt.phase       = PH_IDLE;
					res.valid       = 1'b1;
					res.word.status = STATUS_NOSTR;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/json_string_unescape_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string unescape
// Decodes one JSON string literal a byte at a time into characters.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word                      Meaning
//   in_ch     in         text_byte[7:0]            next byte of the JSON text
//   out_ch    out        char_value[23:0], status  decoded character or event
//
// Each accepted byte is held in the input register; the decoder then updates
// the string state and, when the byte completes something, loads the result
// register. While out_ch is ready, a new byte can be accepted every cycle, so
// throughput is one byte per cycle.
// Opening quotes, backslashes and the first three hex digits of a \u escape
// give no result word. Reset (arst_n low) returns the decoder to idle, waiting
// for an opening quote, and empties both registers. When out_ch stalls, the
// byte in the input register waits and in_ch deasserts ready once it is full.
//
module json_string_unescape_top
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    in_ch,
	jsu_out_if.source out_ch
);

	// Input register stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// String decoder state.
	phase_t            phase_q;
	logic [HEX_W-1:0]  hex_q;

	// Result register.
	logic              out_valid_q;
	out_word_t         out_word_q;

	dec_state_t        cur_state;
	dec_state_t        nxt_state;
	dec_result_t       dec_res;
	logic              advance;

	assign cur_state.phase = phase_q;
	assign cur_state.hex   = hex_q;

	jsu_decode u_decode (
		.cur       (cur_state),
		.text_byte (byte_s1),
		.nxt       (nxt_state),
		.res       (dec_res)
	);

	// The held byte moves on once the result register is free or being emptied.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= '0;
		end else if (advance) begin
			phase_q <= nxt_state.phase;
			hex_q   <= nxt_state.hex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && dec_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec_res.valid) begin
			out_word_q <= dec_res.word;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_word_q;

`ifndef SYNTH
	// Only plain characters carry a value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.status != STATUS_CHAR |-> out_ch.data.char_value == '0)
		else $error("event word carries a nonzero character value");

	// Entering the first hex digit always starts from a cleared accumulator.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEX1 |-> hex_q == '0)
		else $error("hex accumulator not cleared at start of escape");

	// A byte held back by a stall stays in the input register unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stalled byte lost or overwritten");

	// A result is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_word_q))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
